>>> hw/rtl/pbfa_pkg.sv
// ----------------------------------------------------------------------------
// pbfa_pkg: shared types and constants for the pollard rho factor block
// ----------------------------------------------------------------------------
package pbfa_pkg;

  localparam int DefDataWidth = 64;
  localparam int SprintW      = 13;
  localparam int RaceLogW     = 6;
  localparam int FoxW         = 16;
  localparam int StatusW      = 2;
  localparam int AddrW        = 4;
  localparam logic [SprintW-1:0]  SprintReset = 13'd128;
  localparam logic [RaceLogW-1:0] RaceReset   = 6'd21;
  localparam logic [FoxW-1:0]     FoxReset    = 16'd1024;
  localparam logic [SprintW-1:0]  SprintMax   = 13'd4096;

  localparam logic [AddrW-1:0] AddrSprint = 4'd0;
  localparam logic [AddrW-1:0] AddrRace   = 4'd4;
  localparam logic [AddrW-1:0] AddrFox    = 4'd8;

  localparam logic [StatusW-1:0] StFound   = 2'd0;
  localparam logic [StatusW-1:0] StFailed  = 2'd1;
  localparam logic [StatusW-1:0] StInvalid = 2'd2;

  // input beat: one attempt
  typedef struct packed {
    logic [63:0] number;
    logic [63:0] start_position;
    logic [63:0] poly_constant;
  } attempt_t;

  // output beat: factor and status
  typedef struct packed {
    logic [63:0]        factor;
    logic [StatusW-1:0] status;
  } outcome_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch operands, reduce x0 and c
    OP_RACE_INIT, // tortoise <= hare, prod <= 1
    OP_STEP_HARE, // hare <= f(hare)
    OP_SET_FOX,   // fox <= hare
    OP_ACC,       // prod <= prod * |hare - tortoise|
    OP_GCD_PROD,  // factor <= gcd(prod, n)
    OP_STEP_FOX,  // fox <= f(fox)
    OP_GCD_FOX    // factor <= gcd(|fox - tortoise|, n)
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   start;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic n_small;
    logic n_even;
    logic factor_one;
    logic factor_n;
    logic factor_good;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RACE, S_WALK, S_SPRINT, S_STEP, S_ACC, S_GCD,
    S_FOX, S_FOXGCD, S_DONE, S_WAIT
  } ctl_state_t;

endpackage

>>> hw/rtl/pbfa_stream_if.sv
// ----------------------------------------------------------------------------
// pbfa_stream_if: valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface pbfa_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pbfa_datapath.sv
// ----------------------------------------------------------------------------
// pbfa_datapath: modular arithmetic registers and shared multi-cycle units
// Bit-serial mul-mod (one bit a cycle), binary gcd (one step a cycle),
// restoring reduction for the operand loads.
// ----------------------------------------------------------------------------
module pbfa_datapath #(
  parameter int DataWidth = pbfa_pkg::DefDataWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbfa_pkg::dp_cmd_t    cmd,
  output pbfa_pkg::dp_stat_t   stat,
  input  logic [DataWidth-1:0] number,
  input  logic [DataWidth-1:0] start_position,
  input  logic [DataWidth-1:0] poly_constant,
  output logic [DataWidth-1:0] factor
);
  import pbfa_pkg::*;

  localparam int W  = DataWidth;
  localparam int CW = $clog2(W + 1);
  localparam int GW = $clog2(2 * W + 2);

  typedef enum logic [2:0] {
    U_IDLE, U_RED_X, U_RED_C, U_MUL, U_GCD_SH, U_GCD
  } unit_t;

  logic [W-1:0] n, c, hare, tortoise, fox, prod, fct;
  unit_t        unit;
  dp_op_t       pend;
  logic [W-1:0] ma, mb, mr;
  logic [CW-1:0] cnt;
  logic [W:0]   rem;
  logic [W-1:0] ga, gb;
  logic [GW-1:0] gk;
  logic [W-1:0] src_lo;

  // modular helpers, operands below n
  function automatic logic [W-1:0] addm(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic logic [W-1:0] adiff(logic [W-1:0] a, logic [W-1:0] b);
    return (a < b) ? b - a : a - b;
  endfunction

  logic [W-1:0] dbl, mr_next;
  always_comb begin
    dbl     = addm(mr, mr, n);
    mr_next = mb[W-1] ? addm(dbl, ma, n) : dbl;
  end

  // restoring reduction step: shift in one bit of src_lo
  logic [W:0] rem_sh;
  always_comb rem_sh = {rem[W-1:0], src_lo[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= U_IDLE;
      pend <= OP_NONE;
    end else begin
      unique case (unit)
        U_IDLE: begin
          unique case (cmd.start ? cmd.op : OP_NONE)
            OP_LOAD: begin
              n <= number; c <= poly_constant; fct <= '0;
              src_lo <= start_position; rem <= '0;
              cnt <= CW'(W); unit <= U_RED_X;
            end
            OP_RACE_INIT: begin
              tortoise <= hare; prod <= {{(W-1){1'b0}}, 1'b1};
            end
            OP_SET_FOX: fox <= hare;
            OP_STEP_HARE, OP_STEP_FOX: begin
              ma <= (cmd.op == OP_STEP_HARE) ? hare : fox;
              mb <= (cmd.op == OP_STEP_HARE) ? hare : fox;
              mr <= '0; cnt <= CW'(W); pend <= cmd.op; unit <= U_MUL;
            end
            OP_ACC: begin
              ma <= adiff(hare, tortoise); mb <= prod;
              mr <= '0; cnt <= CW'(W); pend <= OP_ACC; unit <= U_MUL;
            end
            OP_GCD_PROD, OP_GCD_FOX: begin
              ga <= (cmd.op == OP_GCD_PROD) ? prod : adiff(fox, tortoise);
              gb <= n; gk <= '0; unit <= U_GCD_SH;
            end
            default: ;
          endcase
        end
        U_RED_X, U_RED_C: begin
          src_lo <= {src_lo[W-2:0], 1'b0};
          rem <= (rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            if (unit == U_RED_X) begin
              hare <= ((rem_sh >= {1'b0, n}) ? W'(rem_sh - {1'b0, n}) : W'(rem_sh));
              src_lo <= c; rem <= '0; cnt <= CW'(W); unit <= U_RED_C;
            end else begin
              c <= ((rem_sh >= {1'b0, n}) ? W'(rem_sh - {1'b0, n}) : W'(rem_sh));
              unit <= U_IDLE;
            end
          end
        end
        U_MUL: begin
          mr <= mr_next;
          mb <= {mb[W-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) unit <= U_IDLE;
        end
        U_GCD_SH: begin
          // strip common twos, then odd a-side convention via steps
          if (ga == '0) begin
            fct <= gb; unit <= U_IDLE;
          end else if (gb == '0) begin
            fct <= ga; unit <= U_IDLE;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1; gb <= gb >> 1; gk <= gk + GW'(1);
          end else begin
            unit <= U_GCD;
          end
        end
        U_GCD: begin
          if (!ga[0]) ga <= ga >> 1;
          else if (!gb[0]) gb <= gb >> 1;
          else if (ga == gb) begin
            fct <= ga << gk; unit <= U_IDLE;
          end else if (ga > gb) ga <= (ga - gb) >> 1;
          else gb <= (gb - ga) >> 1;
        end
        default: unit <= U_IDLE;
      endcase
      // finish of a multiply
      if (unit == U_MUL && cnt == CW'(1)) begin
        unique case (pend)
          OP_STEP_HARE: hare <= addm(mr_next, c, n);
          OP_STEP_FOX:  fox  <= addm(mr_next, c, n);
          default:      prod <= mr_next;
        endcase
      end
      // constant n-2 becomes n-1
      if (unit == U_RED_C && cnt == CW'(1)) begin
        if (((rem_sh >= {1'b0, n}) ? W'(rem_sh - {1'b0, n}) : W'(rem_sh))
            == n - W'(2))
          c <= n - W'(1);
      end
    end
  end

  always_comb begin
    stat.busy        = (unit != U_IDLE);
    stat.n_small     = (number < W'(4));
    stat.n_even      = !number[0];
    stat.factor_one  = (fct == W'(1));
    stat.factor_n    = (fct == n);
    stat.factor_good = (fct > W'(1)) && (fct < n);
  end
  assign factor = fct;
endmodule

>>> hw/rtl/pbfa_control.sv
// ----------------------------------------------------------------------------
// pbfa_control: sequencer of races, sprints and the fox race
// ----------------------------------------------------------------------------
module pbfa_control (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pbfa_pkg::StatusW-1:0] status,
  output logic                         quick_two,
  input  logic [pbfa_pkg::SprintW-1:0] sprint_steps,
  input  logic [pbfa_pkg::RaceLogW-1:0] race_limit_log2,
  input  logic [pbfa_pkg::FoxW-1:0]    final_race_steps,
  output pbfa_pkg::dp_cmd_t            cmd,
  input  pbfa_pkg::dp_stat_t           stat
);
  import pbfa_pkg::*;

  ctl_state_t state, state_next;
  logic [32:0] race, sprint, step, limit;
  logic [SprintW-1:0] m;
  logic [RaceLogW-1:0] lg;
  logic [FoxW-1:0] fstep;
  logic [StatusW-1:0] st;
  logic two;
  logic issued;
  logic done;
  logic odd_take;

  // clamp register values to their working ranges
  always_comb begin
    m = (sprint_steps == '0) ? SprintW'(1) :
        (sprint_steps > SprintMax) ? SprintMax : sprint_steps;
    lg = (race_limit_log2 == '0) ? RaceLogW'(1) :
         (race_limit_log2 > RaceLogW'(32)) ? RaceLogW'(32) : race_limit_log2;
    limit = 33'd1 << lg;
  end

  // odd number of four or more needs the full attempt
  assign odd_take = in_valid && !stat.n_small && !stat.n_even;

  // state register, a command stays issued until it completes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      issued <= (state_next == state && !done) ? (issued | cmd.start) : 1'b0;
    end
  end

  assign done = issued && !stat.busy;

  // counters
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          two <= 1'b0;
          race <= 33'd1;
          if (stat.n_small) st <= StInvalid;
          else if (stat.n_even) begin
            st <= StFound; two <= 1'b1;
          end else st <= StFailed;
        end
      end
      S_RACE: begin
        step <= '0; sprint <= '0;
      end
      S_WALK: if (done) step <= step + 33'd1;
      S_SPRINT: step <= '0;
      S_ACC: if (done) step <= step + 33'd1;
      S_GCD: begin
        if (done) begin
          sprint <= sprint + 33'(m);
          if (stat.factor_one && (sprint + 33'(m) >= race)) race <= race << 1;
          fstep <= '0;
        end
      end
      S_FOXGCD: if (done) fstep <= fstep + FoxW'(1);
      S_DONE: if (!two && st != StInvalid)
        st <= stat.factor_good ? StFound : StFailed;
      default: ;
    endcase
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    cmd.start = 1'b0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_WAIT);
    status = st;
    quick_two = two;
    unique case (state)
      S_IDLE: begin
        // operands are latched at the accepting edge
        cmd.op = OP_LOAD; cmd.start = odd_take;
        if (in_valid) state_next = odd_take ? S_LOAD : S_WAIT;
      end
      S_LOAD: begin
        if (!stat.busy) state_next = S_RACE;
      end
      S_RACE: begin
        cmd.op = OP_RACE_INIT; cmd.start = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (step >= race) state_next = S_SPRINT;
        else begin
          cmd.op = OP_STEP_HARE; cmd.start = !issued;
        end
      end
      S_SPRINT: begin
        cmd.op = OP_SET_FOX; cmd.start = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (step >= 33'(m) || step >= race - sprint) state_next = S_GCD;
        else begin
          cmd.op = OP_STEP_HARE; cmd.start = !issued;
          if (done) state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC; cmd.start = !issued;
        if (done) state_next = S_STEP;
      end
      S_GCD: begin
        cmd.op = OP_GCD_PROD; cmd.start = !issued;
        if (done) begin
          if (!stat.factor_one) state_next = stat.factor_n ? S_FOX : S_DONE;
          else if (sprint + 33'(m) < race) state_next = S_SPRINT;
          else if ((race << 1) < limit) state_next = S_RACE;
          else state_next = S_DONE;
        end
      end
      S_FOX: begin
        if (fstep >= final_race_steps) state_next = S_DONE;
        else begin
          cmd.op = OP_STEP_FOX; cmd.start = !issued;
          if (done) state_next = S_FOXGCD;
        end
      end
      S_FOXGCD: begin
        cmd.op = OP_GCD_FOX; cmd.start = !issued;
        if (done) state_next = stat.factor_one ? S_FOX : S_DONE;
      end
      S_DONE: state_next = S_WAIT;
      S_WAIT: if (out_ready) state_next = S_IDLE;
      default: ;
    endcase
  end
endmodule

>>> hw/rtl/pollard_brent_factor_attempt.sv
// ----------------------------------------------------------------------------
// pollard_brent_factor_attempt: one Pollard rho / Brent attempt per beat
// ----------------------------------------------------------------------------
// One attempt at a time: an input beat is taken only when idle, the result
// beat is held until taken, and the block is idle again the cycle after.
// Numbers below four and even numbers answer the cycle after they are taken.
// An odd number first reduces the start value and the constant, then runs
// bit-serial modular multiplies, each issued, stepped through and seen to
// finish: one multiply per walk step, two per sprint step (square, then
// accumulate) and one per fox step. A binary gcd follows every sprint and
// every fox step, and race and sprint setup each take a state of their own.
// Registers are to be written over the APB port only while no attempt is
// in flight; the user is bound to this, the block itself does not enforce it.
module pollard_brent_factor_attempt #(
  parameter int DATA_WIDTH = pbfa_pkg::DefDataWidth
) (
  input  logic        clk,
  input  logic        rst,
  pbfa_stream_if.sink   in_ch,
  pbfa_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pbfa_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pbfa_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [SprintW-1:0]  sprint_steps;
  logic [RaceLogW-1:0] race_limit_log2;
  logic [FoxW-1:0]     final_race_steps;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [W-1:0] fct;
  logic [StatusW-1:0] status;
  logic quick_two;

  // register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sprint_steps <= SprintReset;
      race_limit_log2 <= RaceReset;
      final_race_steps <= FoxReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        AddrSprint: sprint_steps <= pwdata[SprintW-1:0];
        AddrRace:   race_limit_log2 <= pwdata[RaceLogW-1:0];
        AddrFox:    final_race_steps <= pwdata[FoxW-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      AddrSprint: prdata = 32'(sprint_steps);
      AddrRace:   prdata = 32'(race_limit_log2);
      AddrFox:    prdata = 32'(final_race_steps);
      default:    prdata = '0;
    endcase
  end

  pbfa_control u_ctl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status, .quick_two,
    .sprint_steps, .race_limit_log2, .final_race_steps,
    .cmd, .stat
  );

  pbfa_datapath #(.DataWidth(W)) u_dp (
    .clk, .rst, .cmd, .stat,
    .number(in_ch.data.number[W-1:0]),
    .start_position(in_ch.data.start_position[W-1:0]),
    .poly_constant(in_ch.data.poly_constant[W-1:0]),
    .factor(fct)
  );

  // result fields, factor zero unless one was found
  always_comb begin
    out_ch.data.status = status;
    if (quick_two) out_ch.data.factor = 64'd2;
    else if (status == StFound) out_ch.data.factor = 64'(fct);
    else out_ch.data.factor = '0;
  end
endmodule

>>> hw/rtl/pbfa_checker.sv
// ----------------------------------------------------------------------------
// pbfa_checker: port-level checks of the factor block
// ----------------------------------------------------------------------------
module pbfa_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [63:0] factor
);
  import pbfa_pkg::*;

  // no new input while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // failure and invalid carry factor zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == StFailed || status == StInvalid) |-> factor == '0)
    else $error("nonzero factor on failure");

  // found factor is above one
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == StFound |-> factor > 64'd1)
    else $error("trivial factor reported");

  // result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(factor))
    else $error("result dropped");
endmodule

bind pollard_brent_factor_attempt pbfa_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .factor(out_ch.data.factor)
);
